FILE: rtl/bfoc_pkg.sv
// Package for the barometer first-order compensation pipeline.
// Holds field widths, scaling shifts and calibration register indexes.
// No dependencies.
package bfoc_pkg;

    localparam int RAW_W  = 24;
    localparam int CAL_W  = 16;
    localparam int TEMP_W = 19;
    localparam int PRES_W = 22;

    localparam int REF_SHIFT   = 8;
    localparam int TEMP_SHIFT  = 23;
    localparam int OFF_SCALE   = 16;
    localparam int OFF_SHIFT   = 7;
    localparam int SENS_SCALE  = 15;
    localparam int SENS_SHIFT  = 8;
    localparam int PROD_SHIFT  = 21;
    localparam int PRES_SHIFT  = 15;

    localparam logic signed [TEMP_W-1:0] TEMP_BASE = 19'sd2000;

    localparam int ADDR_W = 5;

    typedef enum logic [2:0] {
        REG_PRESSURE_SENS  = 3'd0,
        REG_PRESSURE_OFF   = 3'd1,
        REG_SENS_TEMP_CO   = 3'd2,
        REG_OFF_TEMP_CO    = 3'd3,
        REG_REF_TEMP       = 3'd4,
        REG_TEMP_TEMP_CO   = 3'd5
    } reg_index_t;

endpackage

FILE: rtl/barometer_first_order_compensation.sv
// Barometer first-order compensation: eight-stage pipeline, one item per cycle
// sustained while result_stall is low; the D1 x SENS product is split in two
// 25x18 partial products over two stages to keep each stage short.
// Reset (rst_n, asynchronous, active low) clears all valid bits and sets the
// six calibration registers to zero; payload registers are not reset.
module barometer_first_order_compensation
    import bfoc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,

    input  logic                     sample_valid,
    output logic                     sample_stall,
    input  logic [RAW_W-1:0]         raw_pressure,
    input  logic [RAW_W-1:0]         raw_temperature,

    output logic                     result_valid,
    input  logic                     result_stall,
    output logic signed [TEMP_W-1:0] temperature_centi,
    output logic signed [PRES_W-1:0] pressure_centi
);

    localparam int NSTAGE = 8;
    localparam int DT_W   = RAW_W + 1;
    localparam int MUL_W  = DT_W + CAL_W + 1;
    localparam int OFF_W  = 36;
    localparam int SENS_W = 35;
    localparam int LO_W   = 17;
    localparam int PP_W   = DT_W + SENS_W - LO_W;
    localparam int PROD_W = 60;
    localparam int Q1_W   = 39;
    localparam int DIFF_W = 40;

    // calibration registers
    logic [CAL_W-1:0] pressure_sensitivity_reg;
    logic [CAL_W-1:0] pressure_offset_reg;
    logic [CAL_W-1:0] sens_temp_coeff_reg;
    logic [CAL_W-1:0] offset_temp_coeff_reg;
    logic [CAL_W-1:0] reference_temperature_reg;
    logic [CAL_W-1:0] temp_temp_coeff_reg;

    logic       cfg_write;
    reg_index_t cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = reg_index_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pressure_sensitivity_reg  <= '0;
            pressure_offset_reg       <= '0;
            sens_temp_coeff_reg       <= '0;
            offset_temp_coeff_reg     <= '0;
            reference_temperature_reg <= '0;
            temp_temp_coeff_reg       <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_PRESSURE_SENS: pressure_sensitivity_reg  <= pwdata[CAL_W-1:0];
                REG_PRESSURE_OFF:  pressure_offset_reg       <= pwdata[CAL_W-1:0];
                REG_SENS_TEMP_CO:  sens_temp_coeff_reg       <= pwdata[CAL_W-1:0];
                REG_OFF_TEMP_CO:   offset_temp_coeff_reg     <= pwdata[CAL_W-1:0];
                REG_REF_TEMP:      reference_temperature_reg <= pwdata[CAL_W-1:0];
                REG_TEMP_TEMP_CO:  temp_temp_coeff_reg       <= pwdata[CAL_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (cfg_idx)
            REG_PRESSURE_SENS: prdata[CAL_W-1:0] = pressure_sensitivity_reg;
            REG_PRESSURE_OFF:  prdata[CAL_W-1:0] = pressure_offset_reg;
            REG_SENS_TEMP_CO:  prdata[CAL_W-1:0] = sens_temp_coeff_reg;
            REG_OFF_TEMP_CO:   prdata[CAL_W-1:0] = offset_temp_coeff_reg;
            REG_REF_TEMP:      prdata[CAL_W-1:0] = reference_temperature_reg;
            REG_TEMP_TEMP_CO:  prdata[CAL_W-1:0] = temp_temp_coeff_reg;
            default:           prdata = '0;
        endcase
    end

    // pipeline control: a stage loads when empty or when the next one loads
    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] valid_next;
    logic [NSTAGE-1:0] load;

    always_comb
    begin
        load[NSTAGE-1] = !valid_reg[NSTAGE-1] || !result_stall;
        for (int k = NSTAGE - 2; k >= 0; k--)
        begin
            load[k] = !valid_reg[k] || load[k+1];
        end
        valid_next[0] = load[0] ? sample_valid : valid_reg[0];
        for (int k = 1; k < NSTAGE; k++)
        begin
            valid_next[k] = load[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign sample_stall = !load[0];
    assign result_valid = valid_reg[NSTAGE-1];

    // stage 0: dT
    logic [RAW_W-1:0]       d1_s0_reg;
    logic signed [DT_W-1:0] dt_s0_reg;
    logic signed [DT_W-1:0] dt_next;

    assign dt_next = $signed({1'b0, raw_temperature})
                   - $signed({1'b0, reference_temperature_reg, {REF_SHIFT{1'b0}}});

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            d1_s0_reg <= raw_pressure;
            dt_s0_reg <= dt_next;
        end
    end

    // stage 1: calibration products
    logic [RAW_W-1:0]        d1_s1_reg;
    logic signed [MUL_W-1:0] pt_s1_reg;
    logic signed [MUL_W-1:0] po_s1_reg;
    logic signed [MUL_W-1:0] ps_s1_reg;

    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            d1_s1_reg <= d1_s0_reg;
            pt_s1_reg <= MUL_W'(dt_s0_reg) * MUL_W'($signed({1'b0, temp_temp_coeff_reg}));
            po_s1_reg <= MUL_W'(dt_s0_reg) * MUL_W'($signed({1'b0, offset_temp_coeff_reg}));
            ps_s1_reg <= MUL_W'(dt_s0_reg) * MUL_W'($signed({1'b0, sens_temp_coeff_reg}));
        end
    end

    // stage 2: TEMP, OFF, SENS (shifts round toward zero)
    logic signed [MUL_W-1:0]  tq;
    logic signed [MUL_W-1:0]  oq;
    logic signed [MUL_W-1:0]  sq;
    logic signed [TEMP_W-1:0] temp_next;
    logic signed [OFF_W-1:0]  off_next;
    logic signed [SENS_W-1:0] sens_next;

    assign tq = (pt_s1_reg + $signed({{(MUL_W-TEMP_SHIFT){1'b0}},
                                      {TEMP_SHIFT{pt_s1_reg[MUL_W-1]}}})) >>> TEMP_SHIFT;
    assign oq = (po_s1_reg + $signed({{(MUL_W-OFF_SHIFT){1'b0}},
                                      {OFF_SHIFT{po_s1_reg[MUL_W-1]}}})) >>> OFF_SHIFT;
    assign sq = (ps_s1_reg + $signed({{(MUL_W-SENS_SHIFT){1'b0}},
                                      {SENS_SHIFT{ps_s1_reg[MUL_W-1]}}})) >>> SENS_SHIFT;

    assign temp_next = $signed(tq[TEMP_W-1:0]) + TEMP_BASE;
    assign off_next  = $signed({{(OFF_W-CAL_W-OFF_SCALE){1'b0}}, pressure_offset_reg,
                                {OFF_SCALE{1'b0}}}) + $signed(oq[OFF_W-1:0]);
    assign sens_next = $signed({{(SENS_W-CAL_W-SENS_SCALE){1'b0}}, pressure_sensitivity_reg,
                                {SENS_SCALE{1'b0}}}) + $signed(sq[SENS_W-1:0]);

    logic [RAW_W-1:0]         d1_s2_reg;
    logic signed [TEMP_W-1:0] temp_s2_reg;
    logic signed [OFF_W-1:0]  off_s2_reg;
    logic signed [SENS_W-1:0] sens_s2_reg;

    always_ff @(posedge clk)
    begin
        if (load[2])
        begin
            d1_s2_reg   <= d1_s1_reg;
            temp_s2_reg <= temp_next;
            off_s2_reg  <= off_next;
            sens_s2_reg <= sens_next;
        end
    end

    // stage 3: D1 x SENS partial products
    logic signed [PP_W-1:0]   pl_s3_reg;
    logic signed [PP_W-1:0]   ph_s3_reg;
    logic signed [TEMP_W-1:0] temp_s3_reg;
    logic signed [OFF_W-1:0]  off_s3_reg;

    always_ff @(posedge clk)
    begin
        if (load[3])
        begin
            pl_s3_reg   <= PP_W'($signed({1'b0, d1_s2_reg}))
                         * PP_W'($signed({1'b0, sens_s2_reg[LO_W-1:0]}));
            ph_s3_reg   <= PP_W'($signed({1'b0, d1_s2_reg}))
                         * PP_W'($signed(sens_s2_reg[SENS_W-1:LO_W]));
            temp_s3_reg <= temp_s2_reg;
            off_s3_reg  <= off_s2_reg;
        end
    end

    // stage 4: combine the product
    logic signed [PROD_W-1:0] prod_s4_reg;
    logic signed [TEMP_W-1:0] temp_s4_reg;
    logic signed [OFF_W-1:0]  off_s4_reg;

    always_ff @(posedge clk)
    begin
        if (load[4])
        begin
            prod_s4_reg <= $signed({ph_s3_reg, {LO_W{1'b0}}})
                         + $signed({{(PROD_W-PP_W){pl_s3_reg[PP_W-1]}}, pl_s3_reg});
            temp_s4_reg <= temp_s3_reg;
            off_s4_reg  <= off_s3_reg;
        end
    end

    // stage 5: D1*SENS / 2^21
    logic signed [PROD_W-1:0] pq;
    logic signed [Q1_W-1:0]   q1_s5_reg;
    logic signed [TEMP_W-1:0] temp_s5_reg;
    logic signed [OFF_W-1:0]  off_s5_reg;

    assign pq = (prod_s4_reg + $signed({{(PROD_W-PROD_SHIFT){1'b0}},
                                        {PROD_SHIFT{prod_s4_reg[PROD_W-1]}}})) >>> PROD_SHIFT;

    always_ff @(posedge clk)
    begin
        if (load[5])
        begin
            q1_s5_reg   <= pq[Q1_W-1:0];
            temp_s5_reg <= temp_s4_reg;
            off_s5_reg  <= off_s4_reg;
        end
    end

    // stage 6: subtract OFF
    logic signed [DIFF_W-1:0] diff_s6_reg;
    logic signed [TEMP_W-1:0] temp_s6_reg;

    always_ff @(posedge clk)
    begin
        if (load[6])
        begin
            diff_s6_reg <= $signed({q1_s5_reg[Q1_W-1], q1_s5_reg})
                         - $signed({{(DIFF_W-OFF_W){off_s5_reg[OFF_W-1]}}, off_s5_reg});
            temp_s6_reg <= temp_s5_reg;
        end
    end

    // stage 7: / 2^15 into the output register
    logic signed [DIFF_W-1:0] dq;

    assign dq = (diff_s6_reg + $signed({{(DIFF_W-PRES_SHIFT){1'b0}},
                                        {PRES_SHIFT{diff_s6_reg[DIFF_W-1]}}})) >>> PRES_SHIFT;

    always_ff @(posedge clk)
    begin
        if (load[7])
        begin
            temperature_centi <= temp_s6_reg;
            pressure_centi    <= dq[PRES_W-1:0];
        end
    end

    // assertions
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> (result_valid && result_stall && (&valid_reg)))
        else $error("input stalled while pipeline has room");

    a_last_stage_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[NSTAGE-2] && !result_valid) |=> result_valid)
        else $error("item lost before output register");

    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_write && cfg_idx == REG_PRESSURE_SENS)
        |=> pressure_sensitivity_reg == $past(pwdata[CAL_W-1:0]))
        else $error("calibration write not taken");

endmodule
